/* hw/rtl/u8sv_pkg.sv */
package u8sv_pkg;

  localparam int unsigned MaxBytesW = 16;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CpW       = 21;

  localparam logic [MaxBytesW-1:0] MAX_BYTES_RST = 16'd4096;

  localparam logic [StatusW-1:0] ST_VALID     = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd1;
  localparam logic [StatusW-1:0] ST_TOO_LONG  = 3'd2;
  localparam logic [StatusW-1:0] ST_MALFORMED = 3'd3;
  localparam logic [StatusW-1:0] ST_CONTROL   = 3'd4;

  localparam logic [1:0] CLS_TWO   = 2'd0;
  localparam logic [1:0] CLS_THREE = 2'd1;
  localparam logic [1:0] CLS_FOUR  = 2'd2;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;

  localparam logic [CpW-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI = 21'h00DFFF;

  typedef struct packed {
    logic [1:0]     pend;
    logic [CpW-1:0] cp;
    logic [1:0]     min_cls;
    logic           malformed;
    logic           control;
  } u8sv_state_t;

  function automatic logic [CpW-1:0] class_min(input logic [1:0] cls);
    logic [CpW-1:0] v;
    case (cls)
      CLS_TWO:   v = 21'h000080;
      CLS_THREE: v = 21'h000800;
      default:   v = 21'h010000;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/u8sv_step.sv */
module u8sv_step import u8sv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  u8sv_state_t              st_i,
  input  logic [LENGTH_BITS:0]     cnt_i,
  input  logic [MaxBytesW-1:0]     max_bytes_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  input  logic                     string_empty_i,
  output u8sv_state_t              st_o,
  output logic [LENGTH_BITS:0]     cnt_o,
  output logic                     result_o,
  output logic [StatusW-1:0]       status_o,
  output logic [LENGTH_BITS:0]     byte_count_o
);

  localparam int unsigned CntW = LENGTH_BITS + 1;
  localparam int unsigned CmpW = (CntW > MaxBytesW + 1) ? CntW : MaxBytesW + 1;

  logic [MaxBytesW:0] cap;
  logic [CntW-1:0]    cnt;
  u8sv_state_t        st;
  logic               mal_end;

  assign cap = {1'b0, max_bytes_i} + {{MaxBytesW{1'b0}}, 1'b1};

  always_comb begin
    st      = st_i;
    cnt     = cnt_i;
    mal_end = 1'b0;
    if (CmpW'(cnt_i) < CmpW'(cap)) begin
      cnt = cnt_i + CntW'(1);
    end
    if (data_byte_i < CTRL_LIMIT || data_byte_i == DEL_BYTE) begin
      st.control = 1'b1;
    end
    if (st_i.pend == 2'd0) begin
      if (data_byte_i > ASCII_MAX) begin
        if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
          st.pend    = 2'd1;
          st.cp      = {16'd0, data_byte_i[4:0]};
          st.min_cls = CLS_TWO;
        end else if (data_byte_i >= LEAD3_LO && data_byte_i <= LEAD3_HI) begin
          st.pend    = 2'd2;
          st.cp      = {17'd0, data_byte_i[3:0]};
          st.min_cls = CLS_THREE;
        end else if (data_byte_i >= LEAD4_LO && data_byte_i <= LEAD4_HI) begin
          st.pend    = 2'd3;
          st.cp      = {18'd0, data_byte_i[2:0]};
          st.min_cls = CLS_FOUR;
        end else begin
          st.malformed = 1'b1;
        end
      end
    end else if (data_byte_i[7:6] != 2'b10) begin
      st.malformed = 1'b1;
      st.pend      = 2'd0;
      st.cp        = '0;
      st.min_cls   = CLS_TWO;
    end else begin
      st.cp   = {st_i.cp[CpW-7:0], data_byte_i[5:0]};
      st.pend = st_i.pend - 2'd1;
      if (st.pend == 2'd0) begin
        if (st.cp < class_min(st_i.min_cls) || st.cp > CP_MAX ||
            (st.cp >= SURR_LO && st.cp <= SURR_HI)) begin
          st.malformed = 1'b1;
        end
        st.cp      = '0;
        st.min_cls = CLS_TWO;
      end
    end
    mal_end = st.malformed || (st.pend != 2'd0);

    result_o     = last_byte_i || string_empty_i;
    byte_count_o = cnt;
    if (CmpW'(cnt) > CmpW'(max_bytes_i)) begin
      status_o = ST_TOO_LONG;
    end else if (mal_end) begin
      status_o = ST_MALFORMED;
    end else if (st.control) begin
      status_o = ST_CONTROL;
    end else begin
      status_o = ST_VALID;
    end
    if (string_empty_i) begin
      status_o     = ST_EMPTY;
      byte_count_o = '0;
    end

    if (result_o) begin
      st_o  = '0;
      cnt_o = '0;
    end else begin
      st_o  = st;
      cnt_o = cnt;
    end
  end

endmodule

/* hw/rtl/u8sv_outreg.sv */
module u8sv_outreg import u8sv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [StatusW-1:0]    status_i,
  input  logic [LENGTH_BITS:0]  byte_count_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [StatusW-1:0]    status_o,
  output logic [LENGTH_BITS:0]  byte_count_o
);

  logic                 valid_q, valid_d;
  logic [StatusW-1:0]   status_q;
  logic [LENGTH_BITS:0] count_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
      count_q  <= byte_count_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign status_o     = status_q;
  assign byte_count_o = count_q;

endmodule

/* hw/rtl/utf8_string_validator_unit.sv */
// Channel   Direction  Handshake                 Payload
// in        request in in_valid_i / in_stall_o   data_byte_i, last_byte_i, string_empty_i
// out       result out out_valid_o / out_stall_i status_o, byte_count_o
// cfg       write in   cfg_we_i                  cfg_wdata_i (max_string_bytes)
//
// One request per cycle unless a stalled result holds the input; a last or empty request
// passes the input register and the decode step and loads the result register when free.
// A combinational decode step lies between the input register and the result register.
// Reset clears string state, valid bits and sets the length limit to 4096.
// Stalls on the result side hold only requests that end a string; other bytes pass.
module utf8_string_validator_unit import u8sv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [MaxBytesW-1:0]  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  string_empty_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [StatusW-1:0]    status_o,
  output logic [LENGTH_BITS:0]  byte_count_o
);

  logic [MaxBytesW-1:0] max_q;
  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic                 empty_q;
  u8sv_state_t          st_q, st_d;
  logic [LENGTH_BITS:0] cnt_q, cnt_d;
  logic                 result;
  logic [StatusW-1:0]   status;
  logic [LENGTH_BITS:0] res_count;
  logic                 out_free;
  logic                 go;
  logic                 take;

  assign go         = in_valid_q && (!result || out_free);
  assign in_stall_o = in_valid_q && !go;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= MAX_BYTES_RST;
      in_valid_q <= 1'b0;
      st_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (go) begin
        in_valid_q <= 1'b0;
      end
      if (go) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= data_byte_i;
      last_q  <= last_byte_i;
      empty_q <= string_empty_i;
    end
  end

  u8sv_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .st_i           (st_q),
    .cnt_i          (cnt_q),
    .max_bytes_i    (max_q),
    .data_byte_i    (byte_q),
    .last_byte_i    (last_q),
    .string_empty_i (empty_q),
    .st_o           (st_d),
    .cnt_o          (cnt_d),
    .result_o       (result),
    .status_o       (status),
    .byte_count_o   (res_count)
  );

  u8sv_outreg #(.LENGTH_BITS(LENGTH_BITS)) u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (go && result),
    .status_i     (status),
    .byte_count_i (res_count),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .byte_count_o (byte_count_o)
  );

endmodule

/* hw/rtl/u8sv_checker.sv */
module u8sv_checker import u8sv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [StatusW-1:0]    status_o,
  input logic [LENGTH_BITS:0]  byte_count_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled without result backpressure");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (byte_count_o == '0))
    else $error("empty result with nonzero count");

  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_TOO_LONG) |-> (byte_count_o != '0))
    else $error("too long result with zero count");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result dropped or changed");

endmodule

bind utf8_string_validator_unit u8sv_checker #(.LENGTH_BITS(LENGTH_BITS)) u_u8sv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .byte_count_o (byte_count_o)
);
